### rtl/core/srpid_pkg.sv
// Shared types and constants for the split-range PID controller.
// No dependencies.
`default_nettype none
package srpid_pkg;
	localparam int unsigned DEADBAND_DEF = 32768;
	localparam logic [30:0] LIMIT_RESET = 31'd6553600;

	localparam logic [2:0] REG_KP_HEAT = 3'd0;
	localparam logic [2:0] REG_KI_HEAT = 3'd1;
	localparam logic [2:0] REG_KD_HEAT = 3'd2;
	localparam logic [2:0] REG_KP_COOL = 3'd3;
	localparam logic [2:0] REG_KI_COOL = 3'd4;
	localparam logic [2:0] REG_KD_COOL = 3'd5;
	localparam logic [2:0] REG_HEAT_LIM = 3'd6;
	localparam logic [2:0] REG_COOL_LIM = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ERR, ST_P, ST_KIE, ST_INC, ST_INT, ST_DIVSTART, ST_DIV,
		ST_D, ST_TOT, ST_OUT
	} state_t;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic load;     // capture input word
		logic clear;    // clear command
		logic do_err;
		logic do_p;
		logic do_kie;
		logic do_inc;
		logic do_int;
		logic div_start;
		logic div_step;
		logic do_d;
		logic do_tot;
		logic push;     // move finished drives to the result register
	} ctl_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

### rtl/core/split_range_pid_controller_top.sv
// Split-range PID controller top level.
// Depends on srpid_pkg, srpid_ctrl, srpid_dp.
//
// Usage: present a word on in_valid with command, target, measured and
// time_step; it is taken when in_stall is low. Each word yields one result
// word on out_valid (heater_drive, cooler_drive), held until out_stall is low.
// A sample's result comes from the error, gain and integral steps, the 48-step
// serial divider for the derivative rate plus its done step, and the D and
// total steps; the gain products share one multiplier. A clear goes straight
// from idle to the output state. The next word can be taken in the same cycle as
// a result is presented. One word is in work at a time; while a result waits
// on out_stall the next word is still processed and then holds until the result
// register frees, stalling the input. Gains and limits are written on the cfg
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data) while idle, which the user
// must ensure; the block does not enforce it. Reset (arst_n low) restores gains
// to zero, limits to 100.0, clears the integrator and re-arms seeding.
`default_nettype none
module split_range_pid_controller_top #(
	parameter int unsigned DEADBAND = srpid_pkg::DEADBAND_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              command,
	input  wire logic signed [31:0] target,
	input  wire logic signed [31:0] measured,
	input  wire logic [30:0]       time_step,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [30:0]            heater_drive,
	output logic [30:0]            cooler_drive,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [31:0]       cfg_data
);
	import srpid_pkg::*;
	ctl_t ctl;
	sts_t sts;
	logic res_push, valid_q;

	assign cfg_ready = 1'b1;

	srpid_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_command(command), .out_busy(valid_q && out_stall),
		.sts, .ctl, .in_stall, .res_push
	);

	srpid_dp #(.DEADBAND(DEADBAND)) u_dp (
		.clk, .arst_n, .ctl, .sts, .cfg_we(cfg_valid), .cfg_index, .cfg_data,
		.target, .measured, .time_step, .heat_q(heater_drive), .cool_q(cooler_drive)
	);

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (res_push) valid_q <= 1'b1;
		else if (!out_stall) valid_q <= 1'b0;
	end
	assign out_valid = valid_q;
endmodule
`default_nettype wire

### rtl/core/srpid_ctrl.sv
// Sequencer for the split-range PID controller.
// Depends on srpid_pkg.
`default_nettype none
module srpid_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_command,
	input  wire logic          out_busy,
	input  wire srpid_pkg::sts_t sts,
	output srpid_pkg::ctl_t    ctl,
	output logic               in_stall,
	output logic               res_push
);
	import srpid_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = in_command ? ST_OUT : ST_ERR;
			ST_ERR: state_d = ST_P;
			ST_P: state_d = ST_KIE;
			ST_KIE: state_d = ST_INC;
			ST_INC: state_d = ST_INT;
			ST_INT: state_d = ST_DIVSTART;
			ST_DIVSTART: state_d = ST_DIV;
			ST_DIV: if (sts.div_done) state_d = ST_D;
			ST_D: state_d = ST_TOT;
			ST_TOT: state_d = ST_OUT;
			ST_OUT: if (!out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl = '0;
		in_stall = (state_q != ST_IDLE);
		res_push = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ctl.load = in_valid;
				ctl.clear = in_valid && in_command;
			end
			ST_ERR: ctl.do_err = 1'b1;
			ST_P: ctl.do_p = 1'b1;
			ST_KIE: ctl.do_kie = 1'b1;
			ST_INC: ctl.do_inc = 1'b1;
			ST_INT: ctl.do_int = 1'b1;
			ST_DIVSTART: ctl.div_start = 1'b1;
			ST_DIV: ctl.div_step = 1'b1;
			ST_D: ctl.do_d = 1'b1;
			ST_TOT: ctl.do_tot = 1'b1;
			ST_OUT: begin
				ctl.push = !out_busy;
				res_push = !out_busy;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### rtl/core/srpid_dp.sv
// Datapath: gain registers, state, shared multiplier and serial divider.
// Depends on srpid_pkg.
`default_nettype none
module srpid_dp #(
	parameter int unsigned DEADBAND = srpid_pkg::DEADBAND_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire srpid_pkg::ctl_t ctl,
	output srpid_pkg::sts_t    sts,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [31:0]   cfg_data,
	input  wire logic signed [31:0] target,
	input  wire logic signed [31:0] measured,
	input  wire logic [30:0]   time_step,
	output logic [30:0]        heat_q,
	output logic [30:0]        cool_q
);
	import srpid_pkg::*;
	localparam logic signed [32:0] DB = 33'(DEADBAND);

	logic signed [31:0] kp_h_q, ki_h_q, kd_h_q, kp_c_q, ki_c_q, kd_c_q;
	logic [30:0] hlim_q, clim_q;
	logic signed [31:0] integ_q, prev_q;
	logic first_q;
	logic signed [31:0] tgt_q, pv_q, err_q, p_q, kie_q, inc_q, d_q;
	logic [30:0] dt_q;
	logic [30:0] drv_heat_q, drv_cool_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_h_q <= '0; ki_h_q <= '0; kd_h_q <= '0;
			kp_c_q <= '0; ki_c_q <= '0; kd_c_q <= '0;
			hlim_q <= LIMIT_RESET; clim_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KP_HEAT: kp_h_q <= cfg_data;
				REG_KI_HEAT: ki_h_q <= cfg_data;
				REG_KD_HEAT: kd_h_q <= cfg_data;
				REG_KP_COOL: kp_c_q <= cfg_data;
				REG_KI_COOL: ki_c_q <= cfg_data;
				REG_KD_COOL: kd_c_q <= cfg_data;
				REG_HEAT_LIM: hlim_q <= cfg_data[30:0];
				REG_COOL_LIM: clim_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	wire heat_sel = err_q > 32'sd0;
	wire signed [31:0] kp = heat_sel ? kp_h_q : kp_c_q;
	wire signed [31:0] ki = heat_sel ? ki_h_q : ki_c_q;
	wire signed [31:0] kd = heat_sel ? kd_h_q : kd_c_q;

	// divider: |diff|<<16 / dt, one quotient bit per cycle
	logic [47:0] rem_q;   // remainder window
	logic [47:0] num_q;   // numerator shift-out
	logic [47:0] quo_q;
	logic [5:0] cnt_q;
	logic neg_q;
	logic signed [31:0] rate_q;

	// shared multiplier operands
	logic signed [31:0] ma, mb;
	always_comb begin
		ma = kp; mb = err_q;
		if (ctl.do_kie) begin ma = ki; mb = err_q; end
		else if (ctl.do_inc) begin ma = kie_q; mb = $signed({1'b0, dt_q}); end
		else if (ctl.do_d) begin ma = kd; mb = rate_q; end
	end
	wire signed [63:0] prod = ma * mb;
	wire signed [63:0] pdiv = (prod < 0) ? -((-prod) >>> 16) : (prod >>> 16);
	wire signed [31:0] qm = sat32(66'(pdiv));
	wire signed [31:0] qneg = sat32(-66'(pdiv));

	wire signed [32:0] dsum = 33'(pv_q) - 33'(prev_q);
	wire signed [31:0] dsat = sat32(66'(dsum));
	wire [31:0] dabs = dsat[31] ? 32'(-33'(dsat)) : dsat;
	wire [48:0] trial = {rem_q, num_q[47]} - {18'd0, dt_q};
	wire signed [32:0] isum = 33'(integ_q) + 33'(inc_q);
	wire signed [31:0] isat = sat32(66'(isum));
	wire signed [33:0] tsum = 34'(p_q) + 34'(integ_q) + 34'(d_q);
	wire signed [31:0] tsat = sat32(66'(tsum));
	wire signed [32:0] e33 = 33'(err_q);

	assign sts.div_done = (cnt_q == 6'd0);

	always_ff @(posedge clk) begin
		if (ctl.load) begin tgt_q <= target; pv_q <= measured; dt_q <= time_step; end
		if (ctl.do_err) err_q <= sat32(66'(33'(tgt_q) - 33'(pv_q)));
		if (ctl.do_p) p_q <= qm;
		if (ctl.do_kie) kie_q <= qm;
		if (ctl.do_inc) inc_q <= qm;
		if (ctl.div_start) begin
			rem_q <= '0; num_q <= {dabs, 16'd0}; quo_q <= '0; neg_q <= dsat[31];
		end else if (ctl.div_step && cnt_q != 6'd0) begin
			num_q <= num_q << 1;
			if (!trial[48]) begin
				rem_q <= trial[47:0]; quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= {rem_q[46:0], num_q[47]}; quo_q <= {quo_q[46:0], 1'b0};
			end
		end
		if (ctl.div_step && cnt_q == 6'd0) begin
			if (dt_q == '0) rate_q <= '0;
			else rate_q <= sat32(neg_q ? -66'(quo_q) : 66'(quo_q));
		end
		if (ctl.do_d) d_q <= qneg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (ctl.div_start) cnt_q <= 6'd48;
		else if (ctl.div_step && cnt_q != 6'd0) cnt_q <= cnt_q - 6'd1;
	end

	// controller state and finished drives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0; prev_q <= '0; first_q <= 1'b1;
			drv_heat_q <= '0; drv_cool_q <= '0;
		end else begin
			if (ctl.clear) begin
				integ_q <= '0; first_q <= 1'b1; drv_heat_q <= '0; drv_cool_q <= '0;
			end
			if (ctl.do_err && first_q) begin prev_q <= pv_q; first_q <= 1'b0; end
			if (ctl.do_int) begin
				if (isat > $signed({1'b0, hlim_q})) integ_q <= $signed({1'b0, hlim_q});
				else if (isat < -$signed({1'b0, clim_q})) integ_q <= -$signed({1'b0, clim_q});
				else integ_q <= isat;
			end
			if (ctl.do_d) prev_q <= pv_q;
			if (ctl.do_tot) begin
				drv_heat_q <= '0; drv_cool_q <= '0;
				if (!(e33 > -DB && e33 < DB)) begin
					if (tsat > 0)
						drv_heat_q <= (tsat > $signed({1'b0, hlim_q})) ? hlim_q : tsat[30:0];
					else if (tsat < 0)
						drv_cool_q <= (-33'(tsat) > 33'(clim_q)) ? clim_q : 31'(-33'(tsat));
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heat_q <= '0; cool_q <= '0;
		end else if (ctl.push) begin
			heat_q <= drv_heat_q; cool_q <= drv_cool_q;
		end
	end
endmodule
`default_nettype wire

### tb/sv/tb_split_range_pid_controller_top.sv
// Self-checking testbench for split_range_pid_controller_top.
// Depends on srpid_pkg and the controller RTL; predicts each result word in a local model.
`timescale 1ns / 1ps
`default_nettype none
module tb_split_range_pid_controller_top;
	import srpid_pkg::*;

	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;
	localparam longint DB = 32768;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [30:0] heat;
		logic [30:0] cool;
	} drive_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = 1'b0;
	logic signed [31:0] target = '0;
	logic signed [31:0] measured = '0;
	logic [30:0] time_step = 31'd1;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [30:0] heater_drive;
	logic [30:0] cooler_drive;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	split_range_pid_controller_top i_dut (.*);

	always #4 clk = ~clk;

	// controller image: gains, limits, loop state
	longint gain [0:5];
	longint heat_lim, cool_lim;
	longint integ, prev_pv;
	bit seed_pending;

	drive_t pending_drives[$];
	int unsigned errors = 0;
	int unsigned results_seen = 0;
	int unsigned words_sent = 0;
	longint cycles = 0;
	bit hold_off = 1'b0;
	bit stall_random = 1'b1;

	function automatic longint clamp32(longint v);
		if (v > SMAX) return SMAX;
		if (v < SMIN) return SMIN;
		return v;
	endfunction

	function automatic longint fixmul(longint a, longint b);
		return clamp32((a * b) / 65536);
	endfunction

	// next drives for one input word, updating the loop state
	function automatic drive_t predict_drives(bit cmd, longint tgt, longint pv, longint dt);
		drive_t d;
		longint err, kp, ki, kd, p, rate, dterm, tot;
		d = '0;
		if (cmd) begin
			integ = 0;
			seed_pending = 1'b1;
			return d;
		end
		err = clamp32(tgt - pv);
		if (seed_pending) begin
			prev_pv = pv;
			seed_pending = 1'b0;
		end
		if (err > 0) begin
			kp = gain[REG_KP_HEAT]; ki = gain[REG_KI_HEAT]; kd = gain[REG_KD_HEAT];
		end else begin
			kp = gain[REG_KP_COOL]; ki = gain[REG_KI_COOL]; kd = gain[REG_KD_COOL];
		end
		p = fixmul(kp, err);
		integ = clamp32(integ + fixmul(fixmul(ki, err), dt));
		if (integ > heat_lim) integ = heat_lim;
		if (integ < -cool_lim) integ = -cool_lim;
		rate = (dt != 0) ? clamp32((clamp32(pv - prev_pv) * 65536) / dt) : 0;
		dterm = clamp32((-(kd * rate)) / 65536);
		prev_pv = pv;
		if (!(err > -DB && err < DB)) begin
			tot = clamp32(p + integ + dterm);
			if (tot > 0) d.heat = 31'((tot > heat_lim) ? heat_lim : tot);
			else if (tot < 0) d.cool = 31'((-tot > cool_lim) ? cool_lim : -tot);
		end
		return d;
	endfunction

	// cycle counter and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		drive_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_drives.size() == 0) begin
				$display("%0t: unexpected word heat=%0d cool=%0d", $time,
					heater_drive, cooler_drive);
				errors++;
			end else begin
				want = pending_drives.pop_front();
				if (heater_drive !== want.heat) begin
					$display("%0t: heater_drive expected %0d actual %0d", $time,
						want.heat, heater_drive);
					errors++;
				end
				if (cooler_drive !== want.cool) begin
					$display("%0t: cooler_drive expected %0d actual %0d", $time,
						want.cool, cooler_drive);
					errors++;
				end
			end
		end
	end

	// receiver stall: random gaps, or a long hold-off
	always @(negedge clk) begin
		int w;
		if (hold_off) out_stall <= 1'b1;
		else if (stall_random) begin
			w = $urandom_range(0, 4);
			out_stall <= ($urandom_range(0, 4) < w);
		end else out_stall <= 1'b0;
	end

	// offer one word and wait until it is taken
	task automatic send_word(bit cmd, logic [31:0] tgt, logic [31:0] pv, logic [30:0] dt,
		bit gaps = 1'b1);
		int waits;
		waits = gaps ? $urandom_range(0, 4) : 0;
		repeat (waits) @(negedge clk);
		@(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		target <= tgt;
		measured <= pv;
		time_step <= dt;
		pending_drives.push_back(predict_drives(cmd, $signed(tgt), $signed(pv), dt));
		words_sent++;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_drives.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_KD_COOL) gain[idx] = longint'($signed(val));
		else if (idx == REG_HEAT_LIM) heat_lim = longint'(val[30:0]);
		else cool_lim = longint'(val[30:0]);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// gains drawn in the range -span to +span
	task automatic load_gains(int span);
		for (int r = 0; r <= 5; r++)
			write_reg(r[2:0], $urandom_range(0, 2 * span) - span);
	endtask

	function automatic logic [31:0] rand_q(int span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	// extremes of every field and each special case
	task automatic test_directed();
		write_reg(REG_KP_HEAT, 32'h0002_0000);
		write_reg(REG_KI_HEAT, 32'h0000_8000);
		write_reg(REG_KD_HEAT, 32'h0001_0000);
		write_reg(REG_KP_COOL, 32'h0003_0000);
		write_reg(REG_KI_COOL, 32'h0000_4000);
		write_reg(REG_KD_COOL, 32'hFFFF_0000);
		send_word(1'b0, 32'h0005_0000, 32'h0001_0000, 31'h0001_0000); // seeds previous value
		send_word(1'b0, 32'h0005_0000, 32'h0002_0000, 31'h0000_8000);
		send_word(1'b0, 32'h0000_4000, 32'h0000_0000, 31'h0001_0000); // inside deadband
		send_word(1'b0, 32'h0000_0000, 32'h0000_8000, 31'h0001_0000); // deadband edge
		send_word(1'b0, 32'h0001_0000, 32'h0001_0000, 31'h0001_0000); // zero error
		send_word(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF); // error saturates
		send_word(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 31'd1);
		send_word(1'b0, 32'h0000_0000, 32'h0000_0000, 31'd0);         // zero time step
		send_word(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF); // clear
		send_word(1'b0, 32'hFFFF_0000, 32'h0003_0000, 31'h0000_1000);
		send_word(1'b0, 32'h8000_0000, 32'h8000_0000, 31'd1);
		wait_drained();
		write_reg(REG_KP_HEAT, 32'h7FFF_FFFF);
		write_reg(REG_KP_COOL, 32'h8000_0000);
		write_reg(REG_KI_HEAT, 32'h8000_0000);
		write_reg(REG_KI_COOL, 32'h7FFF_FFFF);
		write_reg(REG_KD_HEAT, 32'h8000_0000);
		write_reg(REG_KD_COOL, 32'h7FFF_FFFF);
		write_reg(REG_HEAT_LIM, 32'hFFFF_FFFF);
		write_reg(REG_COOL_LIM, 32'h0000_0000);
		send_word(1'b0, 32'h7FFF_FFFF, 32'h0000_0000, 31'h7FFF_FFFF);
		send_word(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 31'd1);
		send_word(1'b0, 32'h0100_0000, 32'h8000_0000, 31'h0000_0001);
		send_word(1'b0, 32'h8000_0000, 32'h0100_0000, 31'h4000_0000);
		wait_drained();
		write_reg(REG_HEAT_LIM, 32'h0000_0000);
		write_reg(REG_COOL_LIM, 32'h7FFF_FFFF);
		send_word(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0001_0000);
		send_word(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0001_0000);
		wait_drained();
	endtask

	// realistic samples, clears and full-range words under several gain and limit settings
	task automatic test_random(int words);
		for (int phase = 0; phase < 4; phase++) begin
			load_gains(phase == 3 ? 32'h4000_0000 : 32'h0004_0000);
			write_reg(REG_HEAT_LIM, $urandom_range(0, 32'h7FFF_FFFF) >> (phase * 3));
			write_reg(REG_COOL_LIM, $urandom_range(0, 32'h7FFF_FFFF) >> (phase * 3));
			for (int n = 0; n < words / 4; n++) begin
				case ($urandom_range(0, 9))
					0: send_word(1'b1, $urandom, $urandom, 31'($urandom));
					1: send_word(1'b0, $urandom, $urandom, 31'($urandom));
					default: send_word(1'b0, rand_q(32'h0064_0000), rand_q(32'h0064_0000),
						31'($urandom_range(0, 32'h0004_0000)));
				endcase
			end
			wait_drained();
		end
	endtask

	// receiver holds off while words keep coming, so the input backs up; then a run with no receiver stall
	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int n = 0; n < 6; n++)
				send_word(1'b0, rand_q(32'h0010_0000), rand_q(32'h0010_0000),
					31'($urandom_range(1, 32'h0002_0000)), 1'b0);
		join
		stall_random = 1'b0;
		for (int n = 0; n < 20; n++)
			send_word(1'b0, rand_q(32'h0010_0000), rand_q(32'h0010_0000), 31'h0001_0000, 1'b0);
		stall_random = 1'b1;
		wait_drained();
	endtask

	initial begin
		for (int r = 0; r <= 5; r++) gain[r] = 0;
		heat_lim = longint'(LIMIT_RESET);
		cool_lim = longint'(LIMIT_RESET);
		integ = 0;
		prev_pv = 0;
		seed_pending = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_random(2000);
		$display("Sent %0d words (samples, clears, extremes, back-pressure);", words_sent);
		$display("checked %0d result words over several gain and limit settings.", results_seen);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
rtl/core/srpid_pkg.sv
rtl/core/srpid_ctrl.sv
rtl/core/srpid_dp.sv
rtl/core/split_range_pid_controller_top.sv
tb/sv/tb_split_range_pid_controller_top.sv
